/* hw/rtl/fpalu_pkg.sv */
`timescale 1ns / 1ps
package fpalu_pkg;

    localparam int FRAC_BITS_DEF = 8;

    localparam logic [3:0] OP_ADD = 4'd0;
    localparam logic [3:0] OP_SUB = 4'd1;
    localparam logic [3:0] OP_MUL = 4'd2;
    localparam logic [3:0] OP_DIV = 4'd3;
    localparam logic [3:0] OP_INC = 4'd4;
    localparam logic [3:0] OP_DEC = 4'd5;
    localparam logic [3:0] OP_MIN = 4'd6;
    localparam logic [3:0] OP_MAX = 4'd7;
    localparam logic [3:0] OP_CMP = 4'd8;
    localparam logic [3:0] OP_ITF = 4'd9;
    localparam logic [3:0] OP_FTI = 4'd10;

    typedef struct packed {
        logic [3:0]         operation;
        logic signed [31:0] operand_a;
        logic signed [31:0] operand_b;
    } t_in;

    typedef struct packed {
        logic signed [31:0] result_value;
        logic               a_less;
        logic               a_equal;
        logic               a_greater;
        logic               range_error;
    } t_out;

endpackage

/* hw/rtl/fixed_point_alu.sv */
`timescale 1ns / 1ps
// Signed fixed-point ALU on 32-bit raw words with FRAC_BITS fraction bits.
// Multiply and divide round to nearest with ties away from zero, and every
// result that leaves the 32-bit range saturates and sets range_error, as
// does a zero divisor. The unit is one pipeline of 35 + FRAC_BITS stages
// (43 at the default): an input register, a decode stage, one stage per
// quotient bit of the restoring divider (the multiplier product is formed
// in the first of them), and a round-and-saturate output register. Every
// operation passes through every stage, so words leave in order, and a new
// word is taken every cycle that input is not stalled. A stall at the output is absorbed by empty
// stages first; input is stalled only when no stage can move.
module fixed_point_alu #(
    parameter int FRAC_BITS = fpalu_pkg::FRAC_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  fpalu_pkg::t_in     i_data,
    output logic               o_valid,
    input  logic               i_stall,
    output fpalu_pkg::t_out    o_data
);
    import fpalu_pkg::*;

    localparam int QW    = 32 + FRAC_BITS;
    localparam int DEPTH = QW + 3;
    localparam int LAST  = DEPTH - 1;

    localparam logic [1:0] K_SIMPLE = 2'd0;
    localparam logic [1:0] K_MUL    = 2'd1;
    localparam logic [1:0] K_DIV    = 2'd2;

    localparam logic signed [63:0] S_MAX = 64'sd2147483647;
    localparam logic signed [63:0] S_MIN = -64'sd2147483648;

    typedef struct packed {
        logic [3:0]         op;
        logic               lt;
        logic               eq;
        logic               gt;
        logic [1:0]         kind;
        logic               neg;
        logic signed [31:0] a;
        logic signed [31:0] b;
        logic [31:0]        res;
        logic               err;
        logic [31:0]        ma;
        logic [31:0]        mb;
        logic [31:0]        rem;
        logic [QW-1:0]      quo;
        logic [63:0]        prod;
    } t_stage;

    t_stage r_st [DEPTH];
    t_stage n_st [DEPTH];
    logic   r_vld [DEPTH];
    logic   en [DEPTH];

    function automatic logic [32:0] sat64(input logic signed [63:0] v);
        if (v > S_MAX) begin
            return {1'b1, 32'h7FFF_FFFF};
        end else if (v < S_MIN) begin
            return {1'b1, 32'h8000_0000};
        end
        return {1'b0, v[31:0]};
    endfunction

    // Each stage moves when it is empty or its successor moves.
    always_comb begin
        en[LAST] = !r_vld[LAST] || !i_stall;
        for (int k = LAST - 1; k >= 0; k--) begin
            en[k] = !r_vld[k] || en[k+1];
        end
    end

    assign o_stall = !en[0];

    always_comb begin
        logic signed [63:0] wa, wb, sv;
        logic [32:0]        sr;
        logic [32:0]        t;
        logic               qb;
        logic [63:0]        mag;
        logic               up;

        n_st[0]      = '0;
        n_st[0].op   = i_data.operation;
        n_st[0].a    = i_data.operand_a;
        n_st[0].b    = i_data.operand_b;

        // Decode: compare flags, magnitudes and the simple operations.
        n_st[1]      = r_st[0];
        wa           = 64'(r_st[0].a);
        wb           = 64'(r_st[0].b);
        n_st[1].lt   = r_st[0].a < r_st[0].b;
        n_st[1].eq   = r_st[0].a == r_st[0].b;
        n_st[1].gt   = r_st[0].a > r_st[0].b;
        n_st[1].neg  = r_st[0].a[31] ^ r_st[0].b[31];
        n_st[1].ma   = r_st[0].a[31] ? 32'(-wa) : r_st[0].a;
        n_st[1].mb   = r_st[0].b[31] ? 32'(-wb) : r_st[0].b;
        n_st[1].rem  = '0;
        n_st[1].quo  = QW'(n_st[1].ma) << FRAC_BITS;
        n_st[1].kind = K_SIMPLE;
        sv = '0;
        case (r_st[0].op)
            OP_ADD:  sv = wa + wb;
            OP_SUB:  sv = wa - wb;
            OP_INC:  sv = wa + 64'sd1;
            OP_DEC:  sv = wa - 64'sd1;
            OP_MIN:  sv = (wa < wb) ? wa : wb;
            OP_MAX:  sv = (wa > wb) ? wa : wb;
            OP_ITF:  sv = wa <<< FRAC_BITS;
            OP_FTI:  sv = wa >>> FRAC_BITS;
            OP_MUL:  n_st[1].kind = K_MUL;
            OP_DIV: begin
                if (r_st[0].b == '0) begin
                    sv = r_st[0].a[31] ? S_MIN : S_MAX;
                end else begin
                    n_st[1].kind = K_DIV;
                end
            end
            default: sv = '0;
        endcase
        sr = sat64(sv);
        n_st[1].res = sr[31:0];
        n_st[1].err = sr[32] || (r_st[0].op == OP_DIV && r_st[0].b == '0);

        // One quotient bit per stage; the product is formed in the first.
        for (int k = 2; k <= QW + 1; k++) begin
            n_st[k] = r_st[k-1];
            t  = {r_st[k-1].rem, r_st[k-1].quo[QW-1]};
            qb = t >= {1'b0, r_st[k-1].mb};
            n_st[k].rem = qb ? 32'(t - {1'b0, r_st[k-1].mb}) : t[31:0];
            n_st[k].quo = {r_st[k-1].quo[QW-2:0], qb};
            if (k == 2) begin
                n_st[k].prod = 64'(r_st[k-1].ma) * 64'(r_st[k-1].mb);
            end
        end

        // Round and saturate.
        n_st[LAST] = r_st[LAST-1];
        up  = {r_st[LAST-1].rem, 1'b0} >= {1'b0, r_st[LAST-1].mb};
        if (r_st[LAST-1].kind == K_MUL) begin
            mag = (r_st[LAST-1].prod + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
        end else begin
            mag = 64'(r_st[LAST-1].quo) + 64'(up);
        end
        if (r_st[LAST-1].kind != K_SIMPLE) begin
            if (r_st[LAST-1].neg) begin
                n_st[LAST].err = mag > 64'h8000_0000;
                n_st[LAST].res = n_st[LAST].err ? 32'h8000_0000 : 32'(-mag);
            end else begin
                n_st[LAST].err = mag > 64'h7FFF_FFFF;
                n_st[LAST].res = n_st[LAST].err ? 32'h7FFF_FFFF : mag[31:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < DEPTH; k++) begin
                r_vld[k] <= 1'b0;
            end
        end else begin
            if (en[0]) begin
                r_vld[0] <= i_valid;
            end
            for (int k = 1; k < DEPTH; k++) begin
                if (en[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < DEPTH; k++) begin
            if (en[k]) begin
                r_st[k] <= n_st[k];
            end
        end
    end

    assign o_valid             = r_vld[LAST];
    assign o_data.result_value = r_st[LAST].res;
    assign o_data.a_less       = r_st[LAST].lt;
    assign o_data.a_equal      = r_st[LAST].eq;
    assign o_data.a_greater    = r_st[LAST].gt;
    assign o_data.range_error  = r_st[LAST].err;

    a_flags_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $onehot({o_data.a_less, o_data.a_equal, o_data.a_greater}))
        else $error("compare flags not one-hot");

    a_cmp_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && r_st[LAST].op == OP_CMP) |->
            (o_data.result_value == '0 && !o_data.range_error))
        else $error("compare word carries a result");

    a_empty_takes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_vld[0] |-> !o_stall)
        else $error("input stalled with an empty first stage");

endmodule

/* bench/fixed_point_alu_tb.sv */
`timescale 1ns / 1ps
module fixed_point_alu_tb;
    import fpalu_pkg::*;

    localparam int FB        = FRAC_BITS_DEF;
    localparam int LATENCY   = 35 + FB;
    localparam int MAX_CYCLE = 400000;
    localparam longint S_MAX = 64'sd2147483647;
    localparam longint S_MIN = -64'sd2147483648;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic o_stall;
    t_in  i_data = '0;
    logic o_valid;
    logic i_stall = 1'b0;
    t_out o_data;

    fixed_point_alu #(.FRAC_BITS(FB)) u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_stall(o_stall),
        .i_data(i_data), .o_valid(o_valid), .i_stall(i_stall), .o_data(o_data)
    );

    always #5 i_clk = ~i_clk;

    t_out   expected_words[$];
    int     mismatch_count = 0;
    int     word_count = 0;
    int     op_seen[16];
    int     send_idle_pct = 0;
    int     recv_stall_pct = 0;
    longint cycle_count = 0;

    function automatic longint sat32(input longint v, inout logic err);
        if (v > S_MAX) begin
            err = 1'b1;
            return S_MAX;
        end
        if (v < S_MIN) begin
            err = 1'b1;
            return S_MIN;
        end
        return v;
    endfunction

    function automatic t_out alu_predict(input t_in w);
        t_out   r;
        longint a, b, v, one;
        logic [63:0] mag, num, den;
        logic   err, neg;
        a   = longint'(w.operand_a);
        b   = longint'(w.operand_b);
        one = longint'(1) << FB;
        err = 1'b0;
        v   = 0;
        neg = (a < 0) != (b < 0);
        case (w.operation)
            OP_ADD: v = sat32(a + b, err);
            OP_SUB: v = sat32(a - b, err);
            OP_MUL: begin
                mag = 64'(a < 0 ? -a : a) * 64'(b < 0 ? -b : b);
                mag = (mag + 64'(one >> 1)) >> FB;
                v = sat32(neg ? -longint'(mag) : longint'(mag), err);
            end
            OP_DIV: begin
                if (b == 0) begin
                    err = 1'b1;
                    v = (a < 0) ? S_MIN : S_MAX;
                end else begin
                    num = 64'(a < 0 ? -a : a) << FB;
                    den = 64'(b < 0 ? -b : b);
                    mag = (2 * num + den) / (2 * den);
                    v = sat32(neg ? -longint'(mag) : longint'(mag), err);
                end
            end
            OP_INC: v = sat32(a + 1, err);
            OP_DEC: v = sat32(a - 1, err);
            OP_MIN: v = (a < b) ? a : b;
            OP_MAX: v = (a > b) ? a : b;
            OP_ITF: v = sat32(a * one, err);
            OP_FTI: v = a >>> FB;
            default: v = 0;
        endcase
        r.result_value = v[31:0];
        r.a_less       = a < b;
        r.a_equal      = a == b;
        r.a_greater    = a > b;
        r.range_error  = err;
        return r;
    endfunction

    // Sends one word, holding it until the block takes it.
    task automatic send_word(input logic [3:0] op, input logic [31:0] a,
                             input logic [31:0] b);
        t_in w;
        w.operation = op;
        w.operand_a = a;
        w.operand_b = b;
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_data  <= w;
        // By the falling edge the stall has settled for the coming rising edge.
        @(negedge i_clk);
        while (o_stall) @(negedge i_clk);
        @(posedge i_clk);
        expected_words.push_back(alu_predict(w));
        op_seen[op]++;
    endtask

    // Receiver stall is drawn anew every cycle.
    always @(posedge i_clk) begin
        i_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    always @(posedge i_clk) begin
        t_out exp_w;
        cycle_count <= cycle_count + 1;
        if (i_rst_n && o_valid && !i_stall) begin
            word_count++;
            if (expected_words.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected word %h", o_data);
            end else begin
                exp_w = expected_words.pop_front();
                if (o_data !== exp_w) begin
                    mismatch_count++;
                    if (mismatch_count <= 10) begin
                        $display("mismatch: exp val=%h lt=%b eq=%b gt=%b err=%b",
                                 exp_w.result_value, exp_w.a_less, exp_w.a_equal,
                                 exp_w.a_greater, exp_w.range_error);
                        $display("          got val=%h lt=%b eq=%b gt=%b err=%b",
                                 o_data.result_value, o_data.a_less, o_data.a_equal,
                                 o_data.a_greater, o_data.range_error);
                    end
                end
            end
        end
        if (cycle_count > MAX_CYCLE) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("end of test: mismatches");
            $finish;
        end
    end

    task automatic wait_drained();
        i_valid <= 1'b0;
        while (expected_words.size() != 0) @(posedge i_clk);
    endtask

    function automatic logic [31:0] edgy_value();
        case ($urandom_range(7))
            0: return 32'h7FFFFFFF;
            1: return 32'h80000000;
            2: return 32'h0;
            3: return 32'(1 << FB);
            4: return -32'(1 << FB);
            5: return $urandom_range(2047) - 1024;
            default: return $urandom;
        endcase
    endfunction

    task automatic test_directed();
        logic [3:0] op;
        for (int k = 0; k <= 15; k++) begin
            op = 4'(k);
            send_word(op, 32'h7FFFFFFF, 32'h80000000);
        end
        send_word(OP_DIV, 32'h00000300, 32'h0);
        send_word(OP_DIV, 32'hFFFFFD00, 32'h0);
        send_word(OP_MUL, 32'h00000180, 32'h00000001);
        send_word(OP_MUL, 32'hFFFFFE80, 32'h00000001);
        send_word(OP_INC, 32'h7FFFFFFF, 32'h0);
        send_word(OP_DEC, 32'h80000000, 32'h0);
        send_word(OP_MIN, 32'h00001234, 32'h00001234);
        send_word(OP_FTI, 32'hFFFFFF01, 32'h0);
        send_word(OP_DIV, 32'h00000001, 32'h00000200);
    endtask

    task automatic test_random(input int n, input int idle, input int stall);
        logic [3:0] op;
        logic [31:0] a, b;
        send_idle_pct  = idle;
        recv_stall_pct = stall;
        for (int k = 0; k < n; k++) begin
            op = ($urandom_range(9) == 0) ? 4'($urandom_range(15, 11))
                                         : 4'($urandom_range(10));
            a = edgy_value();
            b = ($urandom_range(7) == 0) ? a : edgy_value();
            send_word(op, a, b);
        end
    endtask

    // Sends ten words, holds off until every word in flight has come back, then sends ten more.
    task automatic test_drain_pause();
        send_idle_pct  = 0;
        recv_stall_pct = 30;
        for (int k = 0; k < 10; k++)
            send_word(4'($urandom_range(10)), $urandom, $urandom);
        wait_drained();
        for (int k = 0; k < 10; k++)
            send_word(4'($urandom_range(10)), $urandom, $urandom);
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_random(230, 0, 0);
        test_random(220, 66, 0);
        test_random(220, 0, 66);
        test_random(200, 7, 7);
        test_drain_pause();
        recv_stall_pct = 0;
        wait_drained();
        repeat (LATENCY + 10) @(posedge i_clk);
        $display("%0d words checked over all operation codes, with sender gaps,",
                 word_count);
        $display("receiver stalls, saturation, rounding and zero divisors.");
        if (mismatch_count == 0 && expected_words.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("%0d mismatches, %0d words missing", mismatch_count,
                     expected_words.size());
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
